FILE: src/tst_pkg.sv
// Shared constants for the transaction state table: operation and status codes, sizes.
package tst_pkg;

    localparam int FUNC_W   = 3;
    localparam int ID_W     = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;

    localparam int DEF_TABLE_SLOTS = 16;
    localparam int DEF_KEY_BITS    = 64;

    localparam logic [FUNC_W-1:0] FN_START    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_UPDATE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_COMMIT   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ROLLBACK = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PURGE    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_GET      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_STARTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ROLLED_BACK = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COMMITTED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ACTIVE      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd6;

endpackage

FILE: src/transaction_state_table.sv
// Transaction state table: associative table of open transactions keyed by id.
//
//   Channel   Handshake          Beat fields
//   command   start / busy       i_func, i_tx_id
//   result    o_done (strobe)    o_status, o_slot
//
// A command beat is registered into r_func and r_key when it is accepted, and its
// result is then registered into r_status, r_slot and r_done, which drives o_done.
// One beat is accepted every cycle; busy stays low, the key match and free-slot
// search over all slots are done combinationally between the two registers.
// Reset clears all valid and mark bits at once; no clearing pass is needed.
// The receiver cannot stall, so each result strobe lasts exactly one cycle.
module transaction_state_table #(
    parameter int TABLE_SLOTS = tst_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = tst_pkg::DEF_KEY_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tst_pkg::FUNC_W-1:0]    i_func,
    input  logic [tst_pkg::ID_W-1:0]      i_tx_id,
    output logic                          o_done,
    output logic [tst_pkg::STATUS_W-1:0]  o_status,
    output logic [tst_pkg::SLOT_W-1:0]    o_slot
);
    import tst_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    logic                 r_v;
    logic [FUNC_W-1:0]    r_func;
    logic [KEY_BITS-1:0]  r_key;

    logic [TABLE_SLOTS-1:0] r_valid;
    logic [TABLE_SLOTS-1:0] r_comm;
    logic [TABLE_SLOTS-1:0] r_rb;
    logic [KEY_BITS-1:0]    r_slot_key [TABLE_SLOTS];

    logic                  r_done;
    logic [STATUS_W-1:0]   r_status;
    logic [SLOT_W-1:0]     r_slot;

    logic [TABLE_SLOTS-1:0] hit_vec;
    logic [TABLE_SLOTS-1:0] free_oh;
    logic                   hit_any;
    logic                   free_any;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       free_idx;
    logic                   hit_comm;
    logic                   hit_rb;

    logic [TABLE_SLOTS-1:0] n_valid;
    logic [TABLE_SLOTS-1:0] n_comm;
    logic [TABLE_SLOTS-1:0] n_rb;
    logic                   do_claim;
    logic [STATUS_W-1:0]    n_status;
    logic [IDX_W-1:0]       n_idx;
    logic [IDX_W+SLOT_W-1:0] idx_ext;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= start && !busy;
        end
        if (start && !busy) begin
            r_func <= i_func;
            r_key  <= i_tx_id[KEY_BITS-1:0];
        end
    end

    always_comb begin
        logic hf;
        logic ff;
        hit_idx  = '0;
        free_idx = '0;
        free_oh  = '0;
        hf = 1'b0;
        ff = 1'b0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            hit_vec[i] = r_valid[i] && (r_slot_key[i] == r_key);
            if (hit_vec[i] && !hf) begin
                hf      = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i] && !ff) begin
                ff         = 1'b1;
                free_idx   = IDX_W'(i);
                free_oh[i] = 1'b1;
            end
        end
        hit_any  = hf;
        free_any = ff;
        hit_comm = |(hit_vec & r_comm);
        hit_rb   = |(hit_vec & r_rb);
    end

    always_comb begin
        n_valid  = r_valid;
        n_comm   = r_comm;
        n_rb     = r_rb;
        do_claim = 1'b0;
        n_status = ST_OK;
        n_idx    = hit_any ? hit_idx : '0;
        case (r_func)
            FN_START: begin
                if (hit_any) begin
                    n_status = ST_EXISTS;
                end else if (!free_any) begin
                    n_status = ST_FULL;
                end else begin
                    do_claim = 1'b1;
                    n_idx    = free_idx;
                    n_valid  = r_valid | free_oh;
                    n_comm   = r_comm & ~free_oh;
                    n_rb     = r_rb & ~free_oh;
                end
            end
            FN_UPDATE, FN_COMMIT, FN_ROLLBACK: begin
                if (!hit_any) begin
                    n_status = ST_NOT_STARTED;
                end else if (hit_rb) begin
                    n_status = ST_ROLLED_BACK;
                end else if (hit_comm) begin
                    n_status = ST_COMMITTED;
                end else if (r_func == FN_COMMIT) begin
                    n_comm = r_comm | hit_vec;
                end else if (r_func == FN_ROLLBACK) begin
                    n_rb = r_rb | hit_vec;
                end
            end
            FN_PURGE: begin
                if (!hit_any) begin
                    n_status = ST_NOT_STARTED;
                end else if (!hit_rb && !hit_comm) begin
                    n_status = ST_ACTIVE;
                end else begin
                    n_valid = r_valid & ~hit_vec;
                end
            end
            FN_GET: begin
                n_status = ST_OK;
            end
            default: begin
                n_idx = '0;
            end
        endcase
        idx_ext = {{SLOT_W{1'b0}}, n_idx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_comm  <= '0;
            r_rb    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= r_v;
            if (r_v) begin
                r_valid <= n_valid;
                r_comm  <= n_comm;
                r_rb    <= n_rb;
            end
        end
        if (r_v) begin
            r_status <= n_status;
            r_slot   <= idx_ext[SLOT_W-1:0];
        end
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (r_v && do_claim && free_oh[i]) begin
                r_slot_key[i] <= r_key;
            end
        end
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_slot   = r_slot;

endmodule

FILE: src/tst_checker.sv
// Port-level checker for the transaction state table and its bind.
module tst_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_done,
    input  logic [tst_pkg::STATUS_W-1:0]  o_status,
    input  logic [tst_pkg::SLOT_W-1:0]    o_slot
);
    import tst_pkg::*;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("Accepted beat did not produce a result two cycles later.");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##2 !o_done)
        else $error("Result strobe without an accepted beat.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= ST_FULL))
        else $error("Result status code out of range.");

    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL || o_status == ST_NOT_STARTED)) |-> (o_slot == '0))
        else $error("Slot must be zero when no slot applies.");

endmodule

bind transaction_state_table tst_checker u_tst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_status (o_status),
    .o_slot   (o_slot)
);
